// ----- sv/ecal_pkg.sv -----
// ecal_pkg: shared constants, tables and types for the epoch-to-calendar pipeline
package ecal_pkg;

   localparam int NUM_STAGES = 13;

   // reciprocals: q = (x * RECIP) >> k is exact or one low for every x below 2^k
   localparam logic [23:0] DAY_RECIP  = 24'((64'd1 << 33) / 675);
   localparam logic [6:0]  ERA_RECIP  = 7'((64'd1 << 24) / 146097);
   localparam logic [21:0] WEEK_RECIP = 22'((64'd1 << 24) / 7);
   localparam logic [5:0]  HOUR_RECIP = 6'((64'd1 << 17) / 3600);
   localparam logic [6:0]  MIN_RECIP  = 7'((64'd1 << 12) / 60);
   localparam logic [7:0]  QUAD_RECIP = 8'((64'd1 << 18) / 1460);
   localparam logic [2:0]  CENT_RECIP = 3'((64'd1 << 18) / 36524);
   localparam logic [9:0]  YEAR_RECIP = 10'((64'd1 << 18) / 365);

   // 86400 = 128 * 675
   localparam logic [9:0]  DAY_ODD_FACTOR   = 10'd675;
   localparam logic [19:0] EPOCH_SHIFT      = 20'd719468;
   localparam logic [17:0] DAYS_PER_ERA     = 18'd146097;
   localparam logic [17:0] LAST_DAY_OF_ERA  = 18'd146096;
   localparam logic [15:0] DAYS_PER_CENT    = 16'd36524;
   localparam logic [10:0] DAYS_PER_QUAD    = 11'd1460;
   localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
   localparam logic [2:0]  DAYS_PER_WEEK    = 3'd7;
   localparam logic [2:0]  EPOCH_WEEKDAY    = 3'd4;
   localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN     = 6'd60;
   localparam logic [8:0]  YEARS_PER_CENT   = 9'd100;
   localparam logic [8:0]  YEARS_PER_ERA    = 9'd400;
   localparam logic [10:0] BASE_YEAR        = 11'd1900;
   localparam logic [3:0]  MARCH_BASED_JAN  = 4'd10;
   localparam logic [3:0]  MONTH_FROM_MARCH = 4'd2;
   localparam logic [8:0]  JAN_TO_MAR_DAYS  = 9'd59;
   localparam logic [8:0]  MAR_TO_JAN_DAYS  = 9'd306;
   localparam logic [3:0]  MONTHS_PER_YEAR  = 4'd12;

   typedef logic [NUM_STAGES-1:0] stage_vec_type;

   typedef struct packed {
      logic in_ready;
      logic out_valid;
   } pipe_status_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] weekday;
   } tod_type;

   // first day of each month, counted from March 1
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] day;
      case (mp)
         4'd0:    day = 9'd0;
         4'd1:    day = 9'd31;
         4'd2:    day = 9'd61;
         4'd3:    day = 9'd92;
         4'd4:    day = 9'd122;
         4'd5:    day = 9'd153;
         4'd6:    day = 9'd184;
         4'd7:    day = 9'd214;
         4'd8:    day = 9'd245;
         4'd9:    day = 9'd275;
         4'd10:   day = 9'd306;
         4'd11:   day = 9'd337;
         default: day = 9'd0;
      endcase
      return day;
   endfunction

endpackage

// ----- sv/ecal_if.sv -----
// ecal_req_if and ecal_rsp_if: valid/ready channels for epoch seconds and calendar results
interface ecal_req_if;
   logic               valid;
   logic               ready;
   logic signed [40:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [2:0]  weekday;
   logic [15:0] years_since_1900;
   logic [8:0]  day_of_year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;

   modport source (
      output valid, output second, output minute, output hour, output weekday,
      output years_since_1900, output day_of_year, output month, output day_of_month,
      input ready
   );
   modport sink (
      input valid, input second, input minute, input hour, input weekday,
      input years_since_1900, input day_of_year, input month, input day_of_month,
      output ready
   );
endinterface

// ----- sv/ecal_pipe_ctrl.sv -----
// ecal_pipe_ctrl: stage valid bits and per-stage load enables with bubble collapsing
module ecal_pipe_ctrl import ecal_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic            out_ready,
   output stage_vec_type   stage_en,
   output pipe_status_type status
);

   localparam stage_vec_type ALL_STAGES = '1;

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type prev_valid;

   // a stage may load unless it and every stage after it are full and the output stalls
   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         stage_en[k] = out_ready || !(&(valid_ff | ~(ALL_STAGES << k)));
      end
   end

   assign prev_valid = {valid_ff[NUM_STAGES-2:0], in_valid};
   assign valid_in   = (prev_valid & stage_en) | (valid_ff & ~stage_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign status.in_ready  = stage_en[0];
   assign status.out_valid = valid_ff[NUM_STAGES-1];

endmodule

// ----- sv/epoch_seconds_to_utc_calendar.sv -----
// epoch_seconds_to_utc_calendar: pipelined unix seconds to utc gregorian date and time
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    epoch_seconds (41b signed)
//   rsp      out  valid / ready    second minute hour weekday years_since_1900
//                                  day_of_year month day_of_month
//
// thirteen register stages; one beat per cycle sustained while rsp is ready, the result
// coming from the stage 13 output register. the divisions by constants are reciprocal
// multiplies, each followed one stage later by a compare-and-subtract correction.
// reset clears only the stage valid bits. every stage loads while any later stage has a
// bubble, so req stays ready through an rsp stall until the pipeline is full.
module epoch_seconds_to_utc_calendar import ecal_pkg::*; (
   input logic       clock,
   input logic       reset,
   ecal_req_if.sink   req_bus,
   ecal_rsp_if.source rsp_bus
);

   stage_vec_type   stage_en;
   pipe_status_type pipe_status;

   ecal_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .out_ready (rsp_bus.ready),
      .stage_en  (stage_en),
      .status    (pipe_status)
   );

   assign req_bus.ready = pipe_status.in_ready;
   assign rsp_bus.valid = pipe_status.out_valid;

   // stage 1: clamp
   logic [39:0] secs1_ff, secs1_in;
   // stage 2: day estimate
   logic [39:0] secs2_ff;
   logic [23:0] dq2_ff, dq2_in;
   logic [56:0] day_prod;
   // stage 3: days and second of day
   logic [23:0] days3_ff, days3_in;
   logic [16:0] rem3_ff, rem3_in;
   logic [33:0] day_res;
   logic [10:0] day_rem;
   // stage 4
   logic [23:0] z4_ff, z4_in, w4_ff, w4_in;
   logic [16:0] rem4_ff;
   logic [4:0]  hq4_ff, hq4_in;
   logic [22:0] hour_prod;
   // stage 5
   logic [23:0] z5_ff, w5_ff;
   logic [6:0]  eq5_ff, eq5_in;
   logic [21:0] wq5_ff, wq5_in;
   logic [4:0]  hour5_ff, hour5_in;
   logic [11:0] rs5_ff, rs5_in;
   logic [30:0] era_prod;
   logic [45:0] week_prod;
   logic [16:0] hour_res;
   // stage 6
   logic [6:0]  era6_ff, era6_in;
   logic [17:0] doe6_ff, doe6_in;
   logic [2:0]  weekday6_ff, weekday6_in;
   logic [4:0]  hour6_ff;
   logic [11:0] rs6_ff;
   logic [5:0]  mq6_ff, mq6_in;
   logic [24:0] era_res, week_res;
   logic [18:0] min_prod;
   // stage 7
   logic [6:0]  era7_ff, ae7_ff, ae7_in;
   logic [17:0] doe7_ff;
   logic [2:0]  be7_ff, be7_in;
   logic        c7_ff, c7_in;
   tod_type     tod7_ff, tod7_in;
   logic [25:0] quad_prod;
   logic [20:0] cent_prod;
   logic [11:0] min_res;
   // stage 8
   logic [6:0]  era8_ff;
   logic [17:0] doe8_ff, t8_ff, t8_in;
   tod_type     tod8_ff;
   logic [17:0] quad_res, cent_res;
   logic [6:0]  quad_cnt;
   logic [2:0]  cent_cnt;
   // stage 9
   logic [6:0]  era9_ff;
   logic [17:0] doe9_ff, t9_ff;
   logic [8:0]  ye9_ff, ye9_in;
   tod_type     tod9_ff;
   logic [27:0] year_prod;
   // stage 10
   logic [6:0]  era10_ff;
   logic [17:0] doe10_ff;
   logic [8:0]  yoe10_ff, yoe10_in;
   tod_type     tod10_ff;
   logic [17:0] year_res;
   // stage 11
   logic [8:0]  doy11_ff, doy11_in;
   logic [15:0] year11_ff, year11_in;
   logic        leap11_ff, leap11_in;
   tod_type     tod11_ff;
   logic [1:0]  century;
   logic        cent_start;
   logic [17:0] doy_full;
   // stage 12
   logic [8:0]  doy12_ff;
   logic [15:0] year12_ff;
   logic        leap12_ff;
   logic [3:0]  mp12_ff, mp12_in;
   tod_type     tod12_ff;
   // stage 13: output register
   tod_type     tod13_ff;
   logic [15:0] year13_ff, year13_in;
   logic [8:0]  yday13_ff, yday13_in;
   logic [3:0]  month13_ff, month13_in;
   logic [4:0]  mday13_ff, mday13_in;

   // ---------------- stage 1 ----------------
   assign secs1_in = req_bus.epoch_seconds[40] ? '0 : req_bus.epoch_seconds[39:0];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         secs1_ff <= secs1_in;
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      day_prod = 57'(secs1_ff[39:7]) * 57'(DAY_RECIP);
      dq2_in   = day_prod[56:33];
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         secs2_ff <= secs1_ff;
         dq2_ff   <= dq2_in;
      end
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      day_res = 34'(secs2_ff[39:7]) - 34'(dq2_ff) * 34'(DAY_ODD_FACTOR);
      day_rem = day_res[10:0];
      if (day_rem >= 11'(DAY_ODD_FACTOR)) begin
         days3_in = dq2_ff + 24'd1;
         rem3_in  = {10'(day_rem - 11'(DAY_ODD_FACTOR)), secs2_ff[6:0]};
      end else begin
         days3_in = dq2_ff;
         rem3_in  = {day_rem[9:0], secs2_ff[6:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         days3_ff <= days3_in;
         rem3_ff  <= rem3_in;
      end
   end

   // ---------------- stage 4 ----------------
   always_comb begin
      z4_in     = days3_ff + 24'(EPOCH_SHIFT);
      w4_in     = days3_ff + 24'(EPOCH_WEEKDAY);
      hour_prod = 23'(rem3_ff) * 23'(HOUR_RECIP);
      hq4_in    = hour_prod[21:17];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         z4_ff   <= z4_in;
         w4_ff   <= w4_in;
         rem4_ff <= rem3_ff;
         hq4_ff  <= hq4_in;
      end
   end

   // ---------------- stage 5 ----------------
   always_comb begin
      era_prod  = 31'(z4_ff) * 31'(ERA_RECIP);
      eq5_in    = era_prod[30:24];
      week_prod = 46'(w4_ff) * 46'(WEEK_RECIP);
      wq5_in    = week_prod[45:24];
      hour_res  = rem4_ff - 17'(hq4_ff) * 17'(SECS_PER_HOUR);
      if (hour_res >= 17'(SECS_PER_HOUR)) begin
         hour5_in = hq4_ff + 5'd1;
         rs5_in   = 12'(hour_res - 17'(SECS_PER_HOUR));
      end else begin
         hour5_in = hq4_ff;
         rs5_in   = hour_res[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         z5_ff    <= z4_ff;
         w5_ff    <= w4_ff;
         eq5_ff   <= eq5_in;
         wq5_ff   <= wq5_in;
         hour5_ff <= hour5_in;
         rs5_ff   <= rs5_in;
      end
   end

   // ---------------- stage 6 ----------------
   always_comb begin
      era_res = 25'(z5_ff) - 25'(eq5_ff) * 25'(DAYS_PER_ERA);
      if (era_res >= 25'(DAYS_PER_ERA)) begin
         era6_in = eq5_ff + 7'd1;
         doe6_in = 18'(era_res - 25'(DAYS_PER_ERA));
      end else begin
         era6_in = eq5_ff;
         doe6_in = era_res[17:0];
      end
      week_res = 25'(w5_ff) - 25'(wq5_ff) * 25'(DAYS_PER_WEEK);
      if (week_res[3:0] >= 4'(DAYS_PER_WEEK)) begin
         weekday6_in = 3'(week_res[3:0] - 4'(DAYS_PER_WEEK));
      end else begin
         weekday6_in = week_res[2:0];
      end
      min_prod = 19'(rs5_ff) * 19'(MIN_RECIP);
      mq6_in   = min_prod[17:12];
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         era6_ff     <= era6_in;
         doe6_ff     <= doe6_in;
         weekday6_ff <= weekday6_in;
         hour6_ff    <= hour5_ff;
         rs6_ff      <= rs5_ff;
         mq6_ff      <= mq6_in;
      end
   end

   // ---------------- stage 7 ----------------
   always_comb begin
      quad_prod = 26'(doe6_ff) * 26'(QUAD_RECIP);
      ae7_in    = quad_prod[24:18];
      cent_prod = 21'(doe6_ff) * 21'(CENT_RECIP);
      be7_in    = cent_prod[20:18];
      c7_in     = (doe6_ff == LAST_DAY_OF_ERA);
      min_res   = rs6_ff - 12'(mq6_ff) * 12'(SECS_PER_MIN);
      tod7_in.hour    = hour6_ff;
      tod7_in.weekday = weekday6_ff;
      if (min_res >= 12'(SECS_PER_MIN)) begin
         tod7_in.minute = mq6_ff + 6'd1;
         tod7_in.second = 6'(min_res - 12'(SECS_PER_MIN));
      end else begin
         tod7_in.minute = mq6_ff;
         tod7_in.second = min_res[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         era7_ff <= era6_ff;
         doe7_ff <= doe6_ff;
         ae7_ff  <= ae7_in;
         be7_ff  <= be7_in;
         c7_ff   <= c7_in;
         tod7_ff <= tod7_in;
      end
   end

   // ---------------- stage 8: day of era folded onto a 365-day grid ----------------
   always_comb begin
      quad_res = doe7_ff - 18'(ae7_ff) * 18'(DAYS_PER_QUAD);
      quad_cnt = ae7_ff + 7'(quad_res >= 18'(DAYS_PER_QUAD));
      cent_res = doe7_ff - 18'(be7_ff) * 18'(DAYS_PER_CENT);
      cent_cnt = be7_ff + 3'(cent_res >= 18'(DAYS_PER_CENT));
      t8_in    = doe7_ff - 18'(quad_cnt) + 18'(cent_cnt) - 18'(c7_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         era8_ff <= era7_ff;
         doe8_ff <= doe7_ff;
         t8_ff   <= t8_in;
         tod8_ff <= tod7_ff;
      end
   end

   // ---------------- stage 9 ----------------
   always_comb begin
      year_prod = 28'(t8_ff) * 28'(YEAR_RECIP);
      ye9_in    = year_prod[26:18];
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         era9_ff <= era8_ff;
         doe9_ff <= doe8_ff;
         t9_ff   <= t8_ff;
         ye9_ff  <= ye9_in;
         tod9_ff <= tod8_ff;
      end
   end

   // ---------------- stage 10: year of era ----------------
   always_comb begin
      year_res = t9_ff - 18'(ye9_ff) * 18'(DAYS_PER_YEAR);
      yoe10_in = ye9_ff + 9'(year_res >= 18'(DAYS_PER_YEAR));
   end

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         era10_ff <= era9_ff;
         doe10_ff <= doe9_ff;
         yoe10_ff <= yoe10_in;
         tod10_ff <= tod9_ff;
      end
   end

   // ---------------- stage 11: day from march 1, leap flag, march-based year ----------
   always_comb begin
      century = 2'(yoe10_ff >= YEARS_PER_CENT)
              + 2'(yoe10_ff >= 9'(2 * YEARS_PER_CENT))
              + 2'(yoe10_ff >= 9'(3 * YEARS_PER_CENT));
      // year mod 400 equals year of era, so the leap rule needs only yoe
      cent_start = (yoe10_ff == 9'd0) || (yoe10_ff == YEARS_PER_CENT)
                || (yoe10_ff == 9'(2 * YEARS_PER_CENT))
                || (yoe10_ff == 9'(3 * YEARS_PER_CENT));
      leap11_in = ((yoe10_ff[1:0] == 2'd0) && !cent_start) || (yoe10_ff == 9'd0);
      doy_full  = doe10_ff - 18'(yoe10_ff) * 18'(DAYS_PER_YEAR)
                - 18'(yoe10_ff[8:2]) + 18'(century);
      doy11_in  = doy_full[8:0];
      year11_in = 16'(era10_ff) * 16'(YEARS_PER_ERA) + 16'(yoe10_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         doy11_ff  <= doy11_in;
         year11_ff <= year11_in;
         leap11_ff <= leap11_in;
         tod11_ff  <= tod10_ff;
      end
   end

   // ---------------- stage 12: month from march ----------------
   always_comb begin
      mp12_in = '0;
      for (int k = 1; k < int'(MONTHS_PER_YEAR); k++) begin
         mp12_in = mp12_in + 4'(doy11_ff >= month_start(4'(k)));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[11]) begin
         doy12_ff  <= doy11_ff;
         year12_ff <= year11_ff;
         leap12_ff <= leap11_ff;
         mp12_ff   <= mp12_in;
         tod12_ff  <= tod11_ff;
      end
   end

   // ---------------- stage 13: civil date ----------------
   always_comb begin
      mday13_in = 5'(doy12_ff - month_start(mp12_ff) + 9'd1);
      if (mp12_ff < MARCH_BASED_JAN) begin
         month13_in = mp12_ff + MONTH_FROM_MARCH;
         yday13_in  = doy12_ff + JAN_TO_MAR_DAYS + 9'(leap12_ff);
         year13_in  = year12_ff - 16'(BASE_YEAR);
      end else begin
         // january and february belong to the next calendar year
         month13_in = mp12_ff - MARCH_BASED_JAN;
         yday13_in  = doy12_ff - MAR_TO_JAN_DAYS;
         year13_in  = year12_ff + 16'd1 - 16'(BASE_YEAR);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[12]) begin
         tod13_ff   <= tod12_ff;
         year13_ff  <= year13_in;
         yday13_ff  <= yday13_in;
         month13_ff <= month13_in;
         mday13_ff  <= mday13_in;
      end
   end

   assign rsp_bus.second           = tod13_ff.second;
   assign rsp_bus.minute           = tod13_ff.minute;
   assign rsp_bus.hour             = tod13_ff.hour;
   assign rsp_bus.weekday          = tod13_ff.weekday;
   assign rsp_bus.years_since_1900 = year13_ff;
   assign rsp_bus.day_of_year      = yday13_ff;
   assign rsp_bus.month            = month13_ff;
   assign rsp_bus.day_of_month     = mday13_ff;

endmodule
